@@ design/csta_pkg.sv @@
// Package for the client session table: constants, codes and types.
`default_nettype none
package csta_pkg;
    localparam int TableDepth  = 64;
    localparam int IdxW        = $clog2(TableDepth);
    localparam int CntW        = 7;
    localparam int MaxMatches  = 10;
    localparam logic [4:0] IdLen = 5'd20;
    localparam logic [15:0] LeaseReset = 16'd30;
    // stored entry: id 160, hash 32, socket 31
    localparam int EntryW = 64 + 64 + 32 + 32 + 31;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_KEEP  = 3'd1,
        OP_QUERY = 3'd2,
        OP_REM   = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_EMIT,
        S_OUT
    } fsm_t;
endpackage
`default_nettype wire

@@ design/client_session_table_aging.sv @@
// Top level of the client session table with aging timeout.
// Sessions live in two RAMs (entry data and expiry) plus a 64-bit valid
// vector. Every operation sweeps all slots through the RAM read port with
// one read per cycle unless a query match stalls the sweep. An item passes
// through a sweep, a commit step, a result step and an idle step before
// the next input transfer is taken. A query match stalls the sweep only
// while an earlier match is still pending and the output register is full,
// and the result step waits for the output register to free.
// The register lease_seconds (byte address 0) is added to now_sec, modulo
// 2^32, to form an expiry.
`default_nettype none
module client_session_table_aging (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [1:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  wire          s_tvalid,
    output logic         s_tready,
    // op[2:0], id_bytes_low[66:3], id_bytes_mid[130:67], id_bytes_high[162:131],
    // id_length[167:163], session_hash[199:168], socket_number[230:200],
    // now_sec[262:231], match_limit[266:263], zero fill to 272
    input  wire  [271:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status[1:0], match_valid[2], match_socket[33:3], match_hash[65:34],
    // entry_count[72:66], zero fill to 80
    output logic [79:0]  m_tdata,
    output logic         m_tlast
);
    localparam int IW = csta_pkg::IdxW;
    localparam int EW = csta_pkg::EntryW;
    localparam int TableDepth_c = csta_pkg::TableDepth;

    logic [15:0] lease_reg;
    assign pready = 1'b1;
    assign prdata = {16'd0, lease_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lease_reg <= csta_pkg::LeaseReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            lease_reg <= pwdata[15:0];
        end
    end

    // latched item
    logic [2:0]   op_reg;
    logic [159:0] id_reg;
    logic [4:0]   len_reg;
    logic [31:0]  hash_reg;
    logic [30:0]  sock_reg;
    logic [31:0]  now_reg;
    logic [31:0]  exp_reg;
    logic [3:0]   cap_reg;

    csta_pkg::fsm_t state_reg, state_next;
    logic [IW:0]    ptr_reg;      // read address counter
    logic           rv_reg;       // read data valid for slot rslot_reg
    logic [IW-1:0]  rslot_reg;
    logic           hit_f_reg, free_f_reg;
    logic [IW-1:0]  hit_reg, free_reg;
    logic [3:0]     nmatch_reg;
    logic [TableDepth_c-1:0] valid_reg;
    logic [6:0]     cnt_reg;

    // latest query match, held until the next one or the final result
    logic           pend_reg;
    logic [30:0]    psock_reg;
    logic [31:0]    phash_reg;

    logic [EW-1:0]  ent_rd;
    logic [31:0]    exp_rd;
    logic           ent_we, exp_we;
    logic [IW-1:0]  ent_wa, exp_wa;
    logic [EW-1:0]  ent_wd;
    logic [IW-1:0]  raddr;

    csta_ram #(.Width(EW), .Depth(TableDepth_c)) u_ent (
        .aclk(aclk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
        .raddr(raddr), .rdata(ent_rd));
    csta_ram #(.Width(32), .Depth(TableDepth_c)) u_exp (
        .aclk(aclk), .we(exp_we), .waddr(exp_wa), .wdata(exp_reg),
        .raddr(raddr), .rdata(exp_rd));

    // output register
    logic        ov_reg;
    logic [1:0]  ost_reg;
    logic        omv_reg;
    logic [30:0] osock_reg;
    logic [31:0] ohash_reg;
    logic        olast_reg;
    logic [6:0]  ocnt_reg;

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, ocnt_reg, ohash_reg, osock_reg, omv_reg, ost_reg};
    assign s_tready = (state_reg == csta_pkg::S_IDLE);

    // match logic on read data
    logic [159:0] rid;
    logic [31:0]  rhash;
    logic [30:0]  rsock;
    logic         slot_v, id_eq, hash_eq;
    assign rid   = ent_rd[159:0];
    assign rhash = ent_rd[191:160];
    assign rsock = ent_rd[222:192];
    assign slot_v  = rv_reg && valid_reg[rslot_reg];
    assign id_eq   = (len_reg == csta_pkg::IdLen) && (rid == id_reg);
    assign hash_eq = (rhash == hash_reg);

    logic out_free;
    assign out_free = !ov_reg || m_tready;
    logic scan_done;
    assign scan_done = ptr_reg[IW];

    logic q_hit;
    assign q_hit = op_reg == csta_pkg::OP_QUERY && slot_v && id_eq
                   && nmatch_reg < cap_reg;

    // sweep stalls when a new match finds the previous one still waiting
    logic advance;
    assign advance = !(pend_reg && q_hit && !out_free);

    // a stall re-reads the slot under test
    assign raddr = advance ? ptr_reg[IW-1:0] : rslot_reg;

    logic        out_load;
    logic [1:0]  out_st;
    logic        out_mv;
    logic [30:0] out_sock;
    logic [31:0] out_hash;
    logic        out_last;

    always_comb begin
        out_load = 1'b0;
        out_st   = csta_pkg::ST_OK;
        out_mv   = 1'b0;
        out_sock = '0;
        out_hash = '0;
        out_last = 1'b1;
        if (state_reg == csta_pkg::S_SCAN) begin
            out_load = pend_reg && q_hit && out_free;
            out_mv   = 1'b1;
            out_sock = psock_reg;
            out_hash = phash_reg;
            out_last = 1'b0;
        end else if (state_reg == csta_pkg::S_OUT) begin
            out_load = out_free;
            case (op_reg)
                csta_pkg::OP_ADD:
                    if (len_reg != csta_pkg::IdLen)
                        out_st = csta_pkg::ST_BAD_LEN;
                    else if (!hit_f_reg && !free_f_reg)
                        out_st = csta_pkg::ST_FULL;
                csta_pkg::OP_QUERY:
                    if (pend_reg) begin
                        out_mv   = 1'b1;
                        out_sock = psock_reg;
                        out_hash = phash_reg;
                    end else begin
                        out_st = csta_pkg::ST_NONE;
                    end
                default: ;
            endcase
        end
    end

    always_comb begin
        ent_we = 1'b0;
        exp_we = 1'b0;
        ent_wa = rslot_reg;
        exp_wa = rslot_reg;
        ent_wd = {sock_reg, hash_reg, id_reg};
        if (state_reg == csta_pkg::S_SCAN && rv_reg && slot_v &&
            op_reg == csta_pkg::OP_KEEP && hash_eq) begin
            exp_we = 1'b1;
        end
        if (state_reg == csta_pkg::S_FIN && op_reg == csta_pkg::OP_ADD &&
            len_reg == csta_pkg::IdLen) begin
            if (hit_f_reg) begin
                exp_we = 1'b1;
                exp_wa = hit_reg;
            end else if (free_f_reg) begin
                exp_we = 1'b1;
                ent_we = 1'b1;
                exp_wa = free_reg;
                ent_wa = free_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            csta_pkg::S_IDLE: if (s_tvalid) state_next = csta_pkg::S_SCAN;
            csta_pkg::S_SCAN: if (scan_done && !rv_reg)
                state_next = csta_pkg::S_FIN;
            csta_pkg::S_FIN: state_next = csta_pkg::S_OUT;
            csta_pkg::S_OUT: if (out_free) state_next = csta_pkg::S_IDLE;
            default: state_next = csta_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg   <= s_tdata[2:0];
            id_reg   <= s_tdata[162:3];
            len_reg  <= s_tdata[167:163];
            hash_reg <= s_tdata[199:168];
            sock_reg <= s_tdata[230:200];
            now_reg  <= s_tdata[262:231];
            exp_reg  <= s_tdata[262:231] + {16'd0, lease_reg};
            cap_reg  <= (s_tdata[266:263] > 4'(csta_pkg::MaxMatches)) ?
                        4'(csta_pkg::MaxMatches) : s_tdata[266:263];
        end
        if (q_hit && advance) begin
            psock_reg <= rsock;
            phash_reg <= rhash;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= csta_pkg::S_IDLE;
            valid_reg  <= '0;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            rv_reg     <= 1'b0;
            rslot_reg  <= '0;
            hit_f_reg  <= 1'b0;
            free_f_reg <= 1'b0;
            hit_reg    <= '0;
            free_reg   <= '0;
            nmatch_reg <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            ost_reg    <= '0;
            omv_reg    <= 1'b0;
            osock_reg  <= '0;
            ohash_reg  <= '0;
            olast_reg  <= 1'b0;
            ocnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= out_load || (ov_reg && !m_tready);
            if (out_load) begin
                ost_reg   <= out_st;
                omv_reg   <= out_mv;
                osock_reg <= out_sock;
                ohash_reg <= out_hash;
                olast_reg <= out_last;
                ocnt_reg  <= cnt_reg;
            end
            case (state_reg)
                csta_pkg::S_IDLE: begin
                    ptr_reg    <= '0;
                    rv_reg     <= 1'b0;
                    hit_f_reg  <= 1'b0;
                    free_f_reg <= 1'b0;
                    nmatch_reg <= '0;
                end
                csta_pkg::S_SCAN: begin
                    if (advance) begin
                        rv_reg    <= !scan_done;
                        rslot_reg <= raddr;
                        if (!scan_done) ptr_reg <= ptr_reg + 1'b1;
                        if (rv_reg) begin
                            case (op_reg)
                                csta_pkg::OP_ADD: begin
                                    if (slot_v && id_eq && hash_eq && !hit_f_reg) begin
                                        hit_f_reg <= 1'b1;
                                        hit_reg   <= rslot_reg;
                                    end
                                    if (!valid_reg[rslot_reg] && !free_f_reg) begin
                                        free_f_reg <= 1'b1;
                                        free_reg   <= rslot_reg;
                                    end
                                end
                                csta_pkg::OP_REM:
                                    if (slot_v && id_eq && hash_eq) begin
                                        valid_reg[rslot_reg] <= 1'b0;
                                        cnt_reg <= cnt_reg - 7'd1;
                                    end
                                csta_pkg::OP_FLUSH:
                                    if (slot_v && exp_rd < now_reg) begin
                                        valid_reg[rslot_reg] <= 1'b0;
                                        cnt_reg <= cnt_reg - 7'd1;
                                    end
                                default: ;
                            endcase
                            if (q_hit) begin
                                pend_reg   <= 1'b1;
                                nmatch_reg <= nmatch_reg + 1'b1;
                            end
                        end
                    end
                end
                csta_pkg::S_FIN: begin
                    if (op_reg == csta_pkg::OP_ADD && len_reg == csta_pkg::IdLen
                        && !hit_f_reg && free_f_reg) begin
                        valid_reg[free_reg] <= 1'b1;
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                csta_pkg::S_OUT: begin
                    if (out_free) pend_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/csta_ram.sv @@
// Generic single-port-write, one-read synchronous RAM with registered read.
`default_nettype none
module csta_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire  [$clog2(Depth)-1:0]  waddr,
    input  wire  [Width-1:0]          wdata,
    input  wire  [$clog2(Depth)-1:0]  raddr,
    output logic [Width-1:0]          rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ test/client_session_table_aging_tb.sv @@
// Testbench for the client session table: random and directed operations checked against a predictor.
`default_nettype none
module client_session_table_aging_tb;

    typedef struct packed {
        logic [1:0]  status;
        logic        match_valid;
        logic [30:0] match_socket;
        logic [31:0] match_hash;
        logic [6:0]  entry_count;
        logic        last;
    } session_result_t;

    class session_scoreboard;
        bit          used [csta_pkg::TableDepth];
        logic [63:0] id_lo [csta_pkg::TableDepth];
        logic [63:0] id_mid [csta_pkg::TableDepth];
        logic [31:0] id_hi [csta_pkg::TableDepth];
        logic [31:0] hash [csta_pkg::TableDepth];
        logic [30:0] sock [csta_pkg::TableDepth];
        logic [31:0] expiry [csta_pkg::TableDepth];
        logic [15:0] lease;
        session_result_t pending[$];
        int errors;
        int checked;

        function new();
            lease = csta_pkg::LeaseReset;
            for (int i = 0; i < csta_pkg::TableDepth; i++) used[i] = 0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [6:0] live();
            int c;
            c = 0;
            for (int i = 0; i < csta_pkg::TableDepth; i++) if (used[i]) c++;
            return c[6:0];
        endfunction

        function bit id_hit(int i, logic [63:0] lo, logic [63:0] mi, logic [31:0] hi,
                            logic [4:0] len);
            return len == csta_pkg::IdLen && id_lo[i] == lo && id_mid[i] == mi &&
                   id_hi[i] == hi;
        endfunction

        function void push(logic [1:0] st, logic mv, logic [30:0] sk, logic [31:0] hs,
                           logic lst);
            session_result_t r;
            r.status = st;
            r.match_valid = mv;
            r.match_socket = sk;
            r.match_hash = hs;
            r.entry_count = live();
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_transfer(logic [271:0] d);
            logic [2:0]  op;
            logic [63:0] lo, mi;
            logic [31:0] hi, hs, now, exp;
            logic [4:0]  len;
            logic [30:0] sk;
            logic [3:0]  lim;
            logic [1:0]  st;
            int hit, free, cap, n;
            op = d[2:0]; lo = d[66:3]; mi = d[130:67]; hi = d[162:131];
            len = d[167:163]; hs = d[199:168]; sk = d[230:200]; now = d[262:231];
            lim = d[266:263];
            exp = now + {16'd0, lease};
            st = csta_pkg::ST_OK;
            case (op)
                csta_pkg::OP_ADD: begin
                    if (len != csta_pkg::IdLen) begin
                        st = csta_pkg::ST_BAD_LEN;
                    end else begin
                        hit = -1; free = -1;
                        for (int i = 0; i < csta_pkg::TableDepth; i++) begin
                            if (used[i]) begin
                                if (hit < 0 && id_hit(i, lo, mi, hi, len) && hash[i] == hs)
                                    hit = i;
                            end else if (free < 0) begin
                                free = i;
                            end
                        end
                        if (hit >= 0) begin
                            expiry[hit] = exp;
                        end else if (free >= 0) begin
                            used[free] = 1; id_lo[free] = lo; id_mid[free] = mi;
                            id_hi[free] = hi; hash[free] = hs; sock[free] = sk;
                            expiry[free] = exp;
                        end else begin
                            st = csta_pkg::ST_FULL;
                        end
                    end
                end
                csta_pkg::OP_KEEP: begin
                    for (int i = 0; i < csta_pkg::TableDepth; i++)
                        if (used[i] && hash[i] == hs) expiry[i] = exp;
                end
                csta_pkg::OP_QUERY: begin
                    cap = lim > csta_pkg::MaxMatches ? csta_pkg::MaxMatches : lim;
                    n = 0;
                    for (int i = 0; i < csta_pkg::TableDepth && n < cap; i++) begin
                        if (used[i] && id_hit(i, lo, mi, hi, len)) begin
                            push(csta_pkg::ST_OK, 1'b1, sock[i], hash[i], 1'b0);
                            n++;
                        end
                    end
                    if (n == 0) push(csta_pkg::ST_NONE, 1'b0, '0, '0, 1'b1);
                    else pending[pending.size()-1].last = 1'b1;
                    return;
                end
                csta_pkg::OP_REM: begin
                    for (int i = 0; i < csta_pkg::TableDepth; i++)
                        if (used[i] && id_hit(i, lo, mi, hi, len) && hash[i] == hs)
                            used[i] = 0;
                end
                csta_pkg::OP_FLUSH: begin
                    for (int i = 0; i < csta_pkg::TableDepth; i++)
                        if (used[i] && expiry[i] < now) used[i] = 0;
                end
                default: ;
            endcase
            push(st, 1'b0, '0, '0, 1'b1);
        endfunction

        function void check_result(logic [79:0] d, logic lst);
            session_result_t got, want;
            got.status = d[1:0]; got.match_valid = d[2]; got.match_socket = d[33:3];
            got.match_hash = d[65:34]; got.entry_count = d[72:66]; got.last = lst;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h last %b", d, lst);
                return;
            end
            want = pending.pop_front();
            if (got !== want || d[79:73] !== 7'd0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d mv=%0d sk=%h hs=%h cnt=%0d last=%0d | act st=%0d mv=%0d sk=%h hs=%h cnt=%0d last=%0d",
                        want.status, want.match_valid, want.match_socket, want.match_hash,
                        want.entry_count, want.last, got.status, got.match_valid,
                        got.match_socket, got.match_hash, got.entry_count, got.last);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [271:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [79:0]  m_tdata;
    logic         m_tlast;

    session_scoreboard sb = new();
    int idle_cycles = 0;
    int items_sent = 0;
    bit timed_out = 0;
    bit sink_run = 1;
    localparam int WatchdogLimit = 20000;

    // pool of ids kept small so queries and removes hit
    logic [159:0] ids [8];
    logic [31:0]  hashes [4];
    logic [31:0]  clock_sec = 32'd1000;

    always #10 aclk = ~aclk;

    client_session_table_aging u_top (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired");
            $display("client_session_table_aging_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_transfer(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    initial begin
        int g;
        @(posedge aclk);
        while (1) begin
            g = sink_run ? 0 : gap_len();
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            if ($urandom_range(0, 199) == 0) sink_run = ~sink_run;
        end
    end

    task automatic apb_write(input logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.lease = value[15:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0 && !timed_out) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_item(input logic [2:0] op, input logic [159:0] id,
                             input logic [4:0] len, input logic [31:0] hs,
                             input logic [30:0] sk, input logic [31:0] now,
                             input logic [3:0] lim, input bit with_gap);
        int g;
        g = with_gap ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= {5'd0, lim, now, sk, hs, len, id[159:128], id[127:64], id[63:0], op};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic random_item();
        logic [2:0]   op;
        logic [159:0] id;
        logic [4:0]   len;
        logic [31:0]  hs;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) op = csta_pkg::OP_ADD;
        else if (r < 52) op = csta_pkg::OP_KEEP;
        else if (r < 72) op = csta_pkg::OP_QUERY;
        else if (r < 84) op = csta_pkg::OP_REM;
        else if (r < 94) op = csta_pkg::OP_FLUSH;
        else op = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8) id = ids[$urandom_range(0, 7)];
        else id = {$urandom, $urandom, $urandom, $urandom, $urandom};
        len = ($urandom_range(0, 9) < 8) ? csta_pkg::IdLen : 5'($urandom_range(0, 31));
        hs = ($urandom_range(0, 9) < 8) ? hashes[$urandom_range(0, 3)] : $urandom;
        clock_sec = clock_sec + $urandom_range(0, 8);
        send_item(op, id, len, hs, 31'($urandom), clock_sec, 4'($urandom_range(0, 15)),
                  $urandom_range(0, 3) != 0);
    endtask

    initial begin
        logic [159:0] ones;
        ones = '1;
        for (int i = 0; i < 8; i++) ids[i] = {$urandom, $urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < 4; i++) hashes[i] = $urandom;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: defaults, extremes, every op
        send_item(csta_pkg::OP_ADD, ids[0], 5'd19, hashes[0], 31'd1, 32'd100, 4'd0, 0);
        send_item(csta_pkg::OP_ADD, ids[0], 5'd31, hashes[0], 31'd1, 32'd100, 4'd0, 0);
        send_item(csta_pkg::OP_ADD, ids[0], csta_pkg::IdLen, hashes[0], 31'd5, 32'd100,
                  4'd0, 0);
        send_item(csta_pkg::OP_ADD, ones, csta_pkg::IdLen, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                  32'hFFFF_FFF0, 4'd15, 0);
        send_item(csta_pkg::OP_ADD, '0, csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd0, 0);
        send_item(csta_pkg::OP_ADD, ids[0], csta_pkg::IdLen, hashes[1], 31'd6, 32'd100,
                  4'd0, 0);
        send_item(csta_pkg::OP_ADD, ids[0], csta_pkg::IdLen, hashes[0], 31'd7, 32'd110,
                  4'd0, 0);
        send_item(csta_pkg::OP_QUERY, ids[0], csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd15, 0);
        send_item(csta_pkg::OP_QUERY, ids[0], csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd1, 0);
        send_item(csta_pkg::OP_QUERY, ids[0], csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd0, 0);
        send_item(csta_pkg::OP_QUERY, ids[0], 5'd19, 32'd0, 31'd0, 32'd0, 4'd10, 0);
        send_item(csta_pkg::OP_QUERY, ones, csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd10, 0);
        send_item(csta_pkg::OP_KEEP, '0, 5'd0, hashes[1], 31'd0, 32'd200, 4'd0, 0);
        send_item(csta_pkg::OP_KEEP, '0, 5'd0, 32'h1234_5678, 31'd0, 32'd200, 4'd0, 0);
        send_item(csta_pkg::OP_FLUSH, '0, 5'd0, 32'd0, 31'd0, 32'd135, 4'd0, 0);
        send_item(csta_pkg::OP_REM, ids[0], csta_pkg::IdLen, hashes[1], 31'd0, 32'd0, 4'd0, 0);
        send_item(csta_pkg::OP_REM, ones, 5'd19, 32'hFFFF_FFFF, 31'd0, 32'd0, 4'd0, 0);
        send_item(3'd5, ones, 5'd31, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd15, 0);
        send_item(3'd7, '0, 5'd0, 32'd0, 31'd0, 32'd0, 4'd0, 0);
        send_item(csta_pkg::OP_FLUSH, '0, 5'd0, 32'd0, 31'd0, 32'hFFFF_FFFF, 4'd0, 0);
        drain();

        // fill the table to overflow with the largest lease
        apb_write(32'hFFFF_FFFF);
        for (int i = 0; i < csta_pkg::TableDepth + 2; i++)
            send_item(csta_pkg::OP_ADD, ids[i % 8] ^ 160'(i), csta_pkg::IdLen, hashes[i % 4],
                      31'($urandom), 32'hFFFF_0000, 4'd10, i[0]);
        send_item(csta_pkg::OP_QUERY, ids[0], csta_pkg::IdLen, 32'd0, 31'd0, 32'd0, 4'd10, 0);
        send_item(csta_pkg::OP_FLUSH, '0, 5'd0, 32'd0, 31'd0, 32'hFFFF_FFFF, 4'd0, 0);
        drain();

        apb_write(32'd0);
        repeat (50) random_item();
        drain();
        apb_write(32'd5);
        repeat (50) random_item();
        drain();
        apb_write(32'h0001_A5A5);
        repeat (50) random_item();
        drain();
        apb_write(32'h0000_FFFF);
        repeat (30) random_item();
        drain();

        $display("covered %0d transfers in, %0d results checked, lease values 0 to 65535,",
                 items_sent, sb.checked);
        $display("including a full table, saturated query limits and flushes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("client_session_table_aging_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("client_session_table_aging_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
